>>> hw/rtl/ccm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccm_pkg
// shared types, codes and geometry constants of the circle collider mover
// ----------------------------------------------------------------------------
package ccm_pkg;

  // screen and body geometry
  localparam int SCREEN_W    = 640;
  localparam int SCREEN_H    = 480;
  localparam int BODY_RADIUS = 10;
  localparam int STEP        = 3;
  localparam int SPEED_LIMIT = 15;

  // field widths
  localparam int POS_W   = 10;
  localparam int VEL_W   = 5;
  localparam int RAD_W   = 8;
  localparam int CFG_W   = 10;
  localparam int IDX_W   = 3;
  localparam int CRD_W   = 13;                 // signed working coordinate
  localparam int SQ_W    = 2 * CRD_W;          // one signed square
  localparam int DIST_W  = SQ_W;               // sum of two squares, unsigned
  localparam int REACH_W = 10;                 // body radius plus obstacle radius
  localparam int RSQ_W   = 2 * REACH_W;

  typedef logic signed [CRD_W-1:0] coord_t;
  typedef logic signed [VEL_W-1:0] vel_t;

  // legal centre span on each axis
  localparam coord_t POS_MIN = coord_t'(BODY_RADIUS);
  localparam coord_t X_MAX   = coord_t'(SCREEN_W - BODY_RADIUS);
  localparam coord_t Y_MAX   = coord_t'(SCREEN_H - BODY_RADIUS);
  localparam logic [DIST_W-1:0] BODY_RSQ = DIST_W'(BODY_RADIUS * BODY_RADIUS);

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    KEY_UP    = 3'd0,
    KEY_DOWN  = 3'd1,
    KEY_LEFT  = 3'd2,
    KEY_RIGHT = 3'd3
  } key_t;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_WALL_LEFT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_WALL_TOP    = 3'd1;
  localparam logic [IDX_W-1:0] REG_WALL_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_WALL_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_OBST_X      = 3'd4;
  localparam logic [IDX_W-1:0] REG_OBST_Y      = 3'd5;
  localparam logic [IDX_W-1:0] REG_OBST_RADIUS = 3'd6;

  typedef struct packed {
    kind_t kind;
    key_t  key;
    logic  is_repeat;
  } item_t;

  // geometry seen by the collision test
  typedef struct packed {
    logic [POS_W-1:0] wall_left;
    logic [POS_W:0]   wall_right;
    logic [POS_W-1:0] wall_top;
    logic [POS_W:0]   wall_bottom;
    logic [POS_W-1:0] obst_x;
    logic [POS_W-1:0] obst_y;
    logic [RSQ_W-1:0] reach_sq;
  } geom_t;

endpackage
`default_nettype wire

>>> hw/rtl/ccm_blocked.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccm_blocked
// flags a candidate centre that leaves the screen, hits the wall or the obstacle
// ----------------------------------------------------------------------------
module ccm_blocked (
  input  ccm_pkg::coord_t cx,
  input  ccm_pkg::coord_t cy,
  input  ccm_pkg::geom_t  geom,
  output logic            hit
);

  ccm_pkg::coord_t wall_lo_x, wall_hi_x, wall_lo_y, wall_hi_y;
  ccm_pkg::coord_t near_x, near_y, wdx, wdy, odx, ody;
  logic signed [ccm_pkg::SQ_W-1:0] wsq_x, wsq_y, osq_x, osq_y;
  logic [ccm_pkg::DIST_W-1:0] wall_d, obst_d;
  logic off_scr, wall_hit, obst_hit;

  always_comb begin
    off_scr = (cx < ccm_pkg::POS_MIN) || (cx > ccm_pkg::X_MAX) ||
              (cy < ccm_pkg::POS_MIN) || (cy > ccm_pkg::Y_MAX);

    wall_lo_x = signed'({3'b000, geom.wall_left});
    wall_hi_x = signed'({2'b00, geom.wall_right});
    wall_lo_y = signed'({3'b000, geom.wall_top});
    wall_hi_y = signed'({2'b00, geom.wall_bottom});

    // nearest point of the wall rectangle
    near_x = (cx < wall_lo_x) ? wall_lo_x : ((cx > wall_hi_x) ? wall_hi_x : cx);
    near_y = (cy < wall_lo_y) ? wall_lo_y : ((cy > wall_hi_y) ? wall_hi_y : cy);
    wdx = near_x - cx;
    wdy = near_y - cy;
    wsq_x = wdx * wdx;
    wsq_y = wdy * wdy;
    wall_d = {1'b0, wsq_x[ccm_pkg::SQ_W-2:0]} + {1'b0, wsq_y[ccm_pkg::SQ_W-2:0]};
    wall_hit = wall_d < ccm_pkg::BODY_RSQ;

    odx = signed'({3'b000, geom.obst_x}) - cx;
    ody = signed'({3'b000, geom.obst_y}) - cy;
    osq_x = odx * odx;
    osq_y = ody * ody;
    obst_d = {1'b0, osq_x[ccm_pkg::SQ_W-2:0]} + {1'b0, osq_y[ccm_pkg::SQ_W-2:0]};
    obst_hit = obst_d < {{(ccm_pkg::DIST_W-ccm_pkg::RSQ_W){1'b0}}, geom.reach_sq};

    hit = off_scr || wall_hit || obst_hit;
  end

endmodule
`default_nettype wire

>>> hw/rtl/ccm_velocity.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccm_velocity
// key press and release update of the saturating x and y velocity
// ----------------------------------------------------------------------------
module ccm_velocity (
  input  ccm_pkg::item_t item,
  input  ccm_pkg::vel_t  vel_x,
  input  ccm_pkg::vel_t  vel_y,
  output ccm_pkg::vel_t  vel_x_nxt,
  output ccm_pkg::vel_t  vel_y_nxt
);

  localparam int SUM_W = ccm_pkg::VEL_W + 1;

  function automatic ccm_pkg::vel_t sat_vel(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(ccm_pkg::SPEED_LIMIT)) begin
      return ccm_pkg::vel_t'(ccm_pkg::SPEED_LIMIT);
    end else if (v < -SUM_W'(ccm_pkg::SPEED_LIMIT)) begin
      return ccm_pkg::vel_t'(-ccm_pkg::SPEED_LIMIT);
    end
    return v[ccm_pkg::VEL_W-1:0];
  endfunction

  logic signed [SUM_W-1:0] step, wx, wy;
  logic key_evt;

  always_comb begin
    key_evt = ((item.kind == ccm_pkg::KIND_PRESS) || (item.kind == ccm_pkg::KIND_RELEASE))
              && !item.is_repeat;
    step = (item.kind == ccm_pkg::KIND_PRESS) ? SUM_W'(ccm_pkg::STEP)
                                              : -SUM_W'(ccm_pkg::STEP);
    wx = {vel_x[ccm_pkg::VEL_W-1], vel_x};
    wy = {vel_y[ccm_pkg::VEL_W-1], vel_y};
    vel_x_nxt = vel_x;
    vel_y_nxt = vel_y;
    if (key_evt) begin
      case (item.key)
        ccm_pkg::KEY_UP:    vel_y_nxt = sat_vel(wy - step);
        ccm_pkg::KEY_DOWN:  vel_y_nxt = sat_vel(wy + step);
        ccm_pkg::KEY_LEFT:  vel_x_nxt = sat_vel(wx - step);
        ccm_pkg::KEY_RIGHT: vel_x_nxt = sat_vel(wx + step);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/circle_collider_move_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circle_collider_move_step
// moves a circular body under key control, with screen, wall and obstacle stops
// ----------------------------------------------------------------------------
// One item per clock while out_stall is low, one result per item. An accepted
// item lands in an input register; from there the move and key logic run in a
// single pass and the position and velocity registers, which double as the
// result register, take the new state. An item goes through the input register
// and then the result register before its result is on the outputs, and the
// block sustains one transfer per cycle on each side while out_stall is low;
// the only throttle is out_stall, which holds the result and, once the
// input register is also full, raises in_stall. A tick checks the x move and
// both possible y moves in parallel (three collision testers), so the y test
// sees the x position that stands after the x move. Configuration writes are
// always taken (cfg_ready is tied high) and must be done while no item is in
// flight; derived wall edges and the squared reach to the obstacle are
// registered from them.
// ----------------------------------------------------------------------------
module circle_collider_move_step (
  input  logic                          clk,
  input  logic                          rst_n,
  // item channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_kind,
  input  logic [2:0]                    in_direction_key,
  input  logic                          in_is_repeat,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ccm_pkg::POS_W-1:0]     out_pos_x,
  output logic [ccm_pkg::POS_W-1:0]     out_pos_y,
  output logic signed [ccm_pkg::VEL_W-1:0] out_vel_x,
  output logic signed [ccm_pkg::VEL_W-1:0] out_vel_y,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ccm_pkg::IDX_W-1:0]     cfg_index,
  input  logic [ccm_pkg::CFG_W-1:0]     cfg_data
);

  // configuration registers
  logic [ccm_pkg::POS_W-1:0] wall_left_r, wall_top_r, wall_width_r, wall_height_r;
  logic [ccm_pkg::POS_W-1:0] obst_x_r, obst_y_r;
  logic [ccm_pkg::RAD_W-1:0] obst_rad_r;
  // derived geometry, registered from the config registers
  logic [ccm_pkg::POS_W:0]     wall_right_r, wall_bottom_r;
  logic [ccm_pkg::RSQ_W-1:0]   reach_sq_r;
  logic [ccm_pkg::REACH_W-1:0] reach;
  ccm_pkg::geom_t geom;

  // input register
  logic           s1_valid_r;
  ccm_pkg::item_t s1_item_r;

  // state, also the result register
  logic                      out_valid_r;
  logic [ccm_pkg::POS_W-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  ccm_pkg::vel_t             vel_x_r, vel_x_nxt, vel_y_r, vel_y_nxt;

  logic in_xfer, advance, is_tick;
  ccm_pkg::coord_t cur_x, cur_y, mov_x, mov_y;
  logic hit_x, hit_y_old, hit_y_new, hit_y;

  assign cfg_ready = 1'b1;

  // result register frees up when empty or when its result transfers
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  // config writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_left_r   <= 10'd300;
      wall_top_r    <= 10'd40;
      wall_width_r  <= 10'd40;
      wall_height_r <= 10'd400;
      obst_x_r      <= 10'd160;
      obst_y_r      <= 10'd120;
      obst_rad_r    <= 8'd10;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ccm_pkg::REG_WALL_LEFT:   wall_left_r   <= cfg_data;
        ccm_pkg::REG_WALL_TOP:    wall_top_r    <= cfg_data;
        ccm_pkg::REG_WALL_WIDTH:  wall_width_r  <= cfg_data;
        ccm_pkg::REG_WALL_HEIGHT: wall_height_r <= cfg_data;
        ccm_pkg::REG_OBST_X:      obst_x_r      <= cfg_data;
        ccm_pkg::REG_OBST_Y:      obst_y_r      <= cfg_data;
        ccm_pkg::REG_OBST_RADIUS: obst_rad_r    <= cfg_data[ccm_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // far wall edges and squared reach, recomputed every cycle
  assign reach = ccm_pkg::REACH_W'(ccm_pkg::BODY_RADIUS)
               + {{(ccm_pkg::REACH_W-ccm_pkg::RAD_W){1'b0}}, obst_rad_r};

  always_ff @(posedge clk) begin
    wall_right_r  <= {1'b0, wall_left_r} + {1'b0, wall_width_r};
    wall_bottom_r <= {1'b0, wall_top_r} + {1'b0, wall_height_r};
    reach_sq_r    <= reach * reach;
  end

  always_comb begin
    geom.wall_left   = wall_left_r;
    geom.wall_right  = wall_right_r;
    geom.wall_top    = wall_top_r;
    geom.wall_bottom = wall_bottom_r;
    geom.obst_x      = obst_x_r;
    geom.obst_y      = obst_y_r;
    geom.reach_sq    = reach_sq_r;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.kind      <= ccm_pkg::kind_t'(in_kind);
      s1_item_r.key       <= ccm_pkg::key_t'(in_direction_key);
      s1_item_r.is_repeat <= in_is_repeat;
    end
  end

  // candidate positions of a tick
  always_comb begin
    cur_x = signed'({3'b000, pos_x_r});
    cur_y = signed'({3'b000, pos_y_r});
    mov_x = cur_x + ccm_pkg::coord_t'(vel_x_r);
    mov_y = cur_y + ccm_pkg::coord_t'(vel_y_r);
  end

  // x move, then the y move from either x outcome
  ccm_blocked u_hit_x (
    .cx   (mov_x),
    .cy   (cur_y),
    .geom (geom),
    .hit  (hit_x)
  );

  ccm_blocked u_hit_y_old (
    .cx   (cur_x),
    .cy   (mov_y),
    .geom (geom),
    .hit  (hit_y_old)
  );

  ccm_blocked u_hit_y_new (
    .cx   (mov_x),
    .cy   (mov_y),
    .geom (geom),
    .hit  (hit_y_new)
  );

  ccm_velocity u_vel (
    .item      (s1_item_r),
    .vel_x     (vel_x_r),
    .vel_y     (vel_y_r),
    .vel_x_nxt (vel_x_nxt),
    .vel_y_nxt (vel_y_nxt)
  );

  // accepted moves always land on screen, so truncation is exact
  always_comb begin
    is_tick   = s1_item_r.kind == ccm_pkg::KIND_TICK;
    hit_y     = hit_x ? hit_y_old : hit_y_new;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    if (is_tick) begin
      if (!hit_x) begin
        pos_x_nxt = mov_x[ccm_pkg::POS_W-1:0];
      end
      if (!hit_y) begin
        pos_y_nxt = mov_y[ccm_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_x_r     <= 10'd10;
      pos_y_r     <= 10'd10;
      vel_x_r     <= '0;
      vel_y_r     <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        pos_x_r     <= pos_x_nxt;
        pos_y_r     <= pos_y_nxt;
        vel_x_r     <= vel_x_nxt;
        vel_y_r     <= vel_y_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = pos_x_r;
  assign out_pos_y = pos_y_r;
  assign out_vel_x = vel_x_r;
  assign out_vel_y = vel_y_r;

endmodule
`default_nettype wire

>>> hw/rtl/ccm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccm_checker
// port-level checks of the circle collider mover, bound to the top level
// ----------------------------------------------------------------------------
module ccm_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_stall,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [ccm_pkg::POS_W-1:0]     out_pos_x,
  input  logic [ccm_pkg::POS_W-1:0]     out_pos_y,
  input  logic signed [ccm_pkg::VEL_W-1:0] out_vel_x,
  input  logic signed [ccm_pkg::VEL_W-1:0] out_vel_y
);

  localparam logic [ccm_pkg::POS_W-1:0] PMIN = ccm_pkg::POS_W'(ccm_pkg::BODY_RADIUS);
  localparam logic [ccm_pkg::POS_W-1:0] XMAX =
    ccm_pkg::POS_W'(ccm_pkg::SCREEN_W - ccm_pkg::BODY_RADIUS);
  localparam logic [ccm_pkg::POS_W-1:0] YMAX =
    ccm_pkg::POS_W'(ccm_pkg::SCREEN_H - ccm_pkg::BODY_RADIUS);
  localparam logic signed [ccm_pkg::VEL_W-1:0] VMAX =
    ccm_pkg::VEL_W'(ccm_pkg::SPEED_LIMIT);

  // input side only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // the body never stands off screen
  a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pos_x >= PMIN && out_pos_x <= XMAX &&
                   out_pos_y >= PMIN && out_pos_y <= YMAX))
    else $error("position outside screen span");

  // velocity kept within the speed limit
  a_vel_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_vel_x <= VMAX && out_vel_x >= -VMAX &&
                   out_vel_y <= VMAX && out_vel_y >= -VMAX))
    else $error("velocity beyond limit");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_pos_x) && $stable(out_pos_y) &&
                                  $stable(out_vel_x) && $stable(out_vel_y)))
    else $error("stalled result changed");

endmodule

bind circle_collider_move_step ccm_checker u_ccm_checker (.*);
`default_nettype wire
